@@ rtl/core/mtep_pkg.sv @@
//------------------------------------------------------------------------------
// MIDI track event parser package
// Shared word types, status codes, event kinds and result helpers.
//------------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  localparam int unsigned TIME_W            = 28;
  localparam int unsigned QUANTITY_BITS_DEF = 28;
  localparam int unsigned HDR_CNT_W         = 3;

  localparam logic [HDR_CNT_W-1:0] HDR_LAST = 3'd7;

  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
  localparam logic [7:0] STATUS_CHAN_LO  = 8'h80;
  localparam logic [7:0] STATUS_CHAN_HI  = 8'hEF;
  localparam logic [7:0] STATUS_NONE     = 8'h00;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;
  localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
  localparam logic [3:0] TYPE_WHEEL      = 4'hE;

  typedef enum logic [3:0] {
    KIND_NOTE_OFF   = 4'd0,
    KIND_NOTE_ON    = 4'd1,
    KIND_KEY_PRESS  = 4'd2,
    KIND_CONTROL    = 4'd3,
    KIND_PROGRAM    = 4'd4,
    KIND_CHAN_PRESS = 4'd5,
    KIND_WHEEL      = 4'd6,
    KIND_META       = 4'd7,
    KIND_SYSEX      = 4'd8,
    KIND_STRAY      = 4'd9
  } event_kind_e;

  typedef enum logic [3:0] {
    PH_STOPPED   = 4'd0,
    PH_HEADER    = 4'd1,
    PH_DELTA     = 4'd2,
    PH_STATUS    = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_SYSEX_LEN = 4'd6,
    PH_PAYLOAD   = 4'd7,
    PH_DATA1     = 4'd8,
    PH_DATA2     = 4'd9
  } phase_e;

  typedef struct packed {
    logic       track_start;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        event_kind;
    logic [TIME_W-1:0] delta_time;
    logic [3:0]        channel;
    logic [7:0]        first_data;
    logic [7:0]        second_data;
    logic [14:0]       wheel_value;
    logic [7:0]        meta_type;
    logic [TIME_W-1:0] payload_length;
    logic [7:0]        payload_byte;
    logic              last_of_payload;
    logic              end_of_track;
  } res_t;

  function automatic logic is_one_data(input logic [7:0] status);
    return (status[7:4] == TYPE_PROGRAM) || (status[7:4] == TYPE_CHAN_PRESS);
  endfunction

  function automatic res_t make_chan(input logic [7:0] status, input logic [7:0] d1,
                                     input logic [7:0] d2, input logic [TIME_W-1:0] delta);
    res_t r;
    r                = '0;
    r.event_kind     = {1'b0, status[6:4]};
    r.delta_time     = delta;
    r.channel        = status[3:0];
    r.first_data     = d1;
    if (!is_one_data(status)) begin
      r.second_data = d2;
    end
    if (status[7:4] == TYPE_WHEEL) begin
      r.wheel_value = 15'({d2, 7'b0}) | 15'(d1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mtep_in_if.sv @@
//------------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one track byte word.
//------------------------------------------------------------------------------
`default_nettype none

interface mtep_in_if;
  import mtep_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mtep_out_if.sv @@
//------------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one parsed event word.
//------------------------------------------------------------------------------
`default_nettype none

interface mtep_out_if;
  import mtep_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mtep_in_reg.sv @@
//------------------------------------------------------------------------------
// Input register
// Holds one accepted byte word until the parser step takes it.
//------------------------------------------------------------------------------
`default_nettype none

module mtep_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire mtep_pkg::in_word_t word_i,
  input  wire logic              take_i,
  output logic                   valid_o,
  output mtep_pkg::in_word_t     word_o
);
  import mtep_pkg::*;

  logic     vld_q, vld_d;
  in_word_t word_q;

  assign ready_o = !vld_q || take_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

  assign valid_o = vld_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ rtl/core/mtep_step.sv @@
//------------------------------------------------------------------------------
// Parser step
// Phase state machine and held fields; decodes one byte per step.
//------------------------------------------------------------------------------
`default_nettype none

module mtep_step #(
  parameter int unsigned QuantityBits = mtep_pkg::QUANTITY_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire mtep_pkg::in_word_t word_i,
  output logic                    res_vld_o,
  output mtep_pkg::res_t          res_o
);
  import mtep_pkg::*;

  localparam int unsigned QW = QuantityBits;

  phase_e                 phase_q, phase_d;
  logic [HDR_CNT_W-1:0]   hcnt_q, hcnt_d;
  logic [QW-1:0]          acc_q, acc_d;
  logic [QW-1:0]          delta_q, delta_d;
  logic [7:0]             last_q, last_d;
  logic [7:0]             cur_q, cur_d;
  logic [7:0]             first_q, first_d;
  logic [7:0]             mtype_q, mtype_d;
  logic [QW-1:0]          rem_q, rem_d;

  logic [7:0]    b;
  logic [QW-1:0] acc_next;
  logic [QW-1:0] rem_dec;
  logic          is_meta_b;
  logic          is_sysex_b;
  logic          is_chan_b;
  logic          eot_hit;

  assign b          = word_i.data_byte;
  assign acc_next   = QW'({acc_q, b[6:0]});
  assign rem_dec    = rem_q - QW'(1);
  assign is_meta_b  = (b == STATUS_META);
  assign is_sysex_b = (b == STATUS_SYSEX) || (b == STATUS_ESCAPE);
  assign is_chan_b  = (b >= STATUS_CHAN_LO) && (b <= STATUS_CHAN_HI);
  assign eot_hit    = (cur_q == STATUS_META) && (mtype_q == META_END_TRACK);

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    acc_d   = acc_q;
    delta_d = delta_q;
    last_d  = last_q;
    cur_d   = cur_q;
    first_d = first_q;
    mtype_d = mtype_q;
    rem_d   = rem_q;
    if (word_i.track_start) begin
      phase_d = PH_HEADER;
      hcnt_d  = HDR_CNT_W'(1);
      acc_d   = '0;
      delta_d = '0;
      last_d  = STATUS_NONE;
      cur_d   = STATUS_NONE;
      first_d = '0;
      mtype_d = '0;
      rem_d   = '0;
    end else begin
      unique case (phase_q)
        PH_STOPPED: begin
        end
        PH_HEADER: begin
          if (hcnt_q >= HDR_LAST) begin
            hcnt_d  = '0;
            acc_d   = '0;
            phase_d = PH_DELTA;
          end else begin
            hcnt_d = hcnt_q + HDR_CNT_W'(1);
          end
        end
        PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
          acc_d = acc_next;
          if (!b[7]) begin
            if (phase_q == PH_DELTA) begin
              delta_d = acc_next;
              acc_d   = '0;
              phase_d = PH_STATUS;
            end else begin
              rem_d = acc_next;
              if (acc_next != '0) begin
                phase_d = PH_PAYLOAD;
              end else begin
                acc_d   = '0;
                phase_d = eot_hit ? PH_STOPPED : PH_DELTA;
              end
            end
          end
        end
        PH_STATUS: begin
          priority if (is_meta_b) begin
            cur_d   = b;
            phase_d = PH_META_TYPE;
          end else if (is_sysex_b) begin
            cur_d   = b;
            acc_d   = '0;
            phase_d = PH_SYSEX_LEN;
          end else if (is_chan_b) begin
            cur_d   = b;
            last_d  = b;
            phase_d = PH_DATA1;
          end else if (last_q == STATUS_NONE) begin
            acc_d   = '0;
            phase_d = PH_DELTA;
          end else begin
            cur_d = last_q;
            if (is_one_data(last_q)) begin
              acc_d   = '0;
              phase_d = PH_DELTA;
            end else begin
              first_d = b;
              phase_d = PH_DATA2;
            end
          end
        end
        PH_META_TYPE: begin
          mtype_d = b;
          acc_d   = '0;
          phase_d = PH_META_LEN;
        end
        PH_PAYLOAD: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            acc_d   = '0;
            phase_d = PH_DELTA;
          end
        end
        PH_DATA1: begin
          if (is_one_data(cur_q)) begin
            acc_d   = '0;
            phase_d = PH_DELTA;
          end else begin
            first_d = b;
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          acc_d   = '0;
          phase_d = PH_DELTA;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [TIME_W-1:0] dt;
    logic              meta;
    dt        = TIME_W'(delta_q);
    meta      = (cur_q == STATUS_META);
    res_vld_o = 1'b0;
    res_o     = '0;
    if (!word_i.track_start) begin
      unique case (phase_q)
        PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
          if (!b[7] && (phase_q != PH_DELTA) && (acc_next == '0)) begin
            res_vld_o             = 1'b1;
            res_o.event_kind      = meta ? KIND_META : KIND_SYSEX;
            res_o.delta_time      = dt;
            res_o.meta_type       = meta ? mtype_q : 8'h00;
            res_o.last_of_payload = 1'b1;
            res_o.end_of_track    = eot_hit;
          end
        end
        PH_STATUS: begin
          if (!is_meta_b && !is_sysex_b && !is_chan_b) begin
            if (last_q == STATUS_NONE) begin
              res_vld_o        = 1'b1;
              res_o.event_kind = KIND_STRAY;
              res_o.delta_time = dt;
              res_o.first_data = b;
            end else if (is_one_data(last_q)) begin
              res_vld_o = 1'b1;
              res_o     = make_chan(last_q, b, 8'h00, dt);
            end
          end
        end
        PH_PAYLOAD: begin
          res_vld_o             = 1'b1;
          res_o.event_kind      = meta ? KIND_META : KIND_SYSEX;
          res_o.delta_time      = dt;
          res_o.meta_type       = meta ? mtype_q : 8'h00;
          res_o.payload_length  = TIME_W'(acc_q);
          res_o.payload_byte    = b;
          res_o.last_of_payload = (rem_dec == '0);
        end
        PH_DATA1: begin
          if (is_one_data(cur_q)) begin
            res_vld_o = 1'b1;
            res_o     = make_chan(cur_q, b, 8'h00, dt);
          end
        end
        PH_DATA2: begin
          res_vld_o = 1'b1;
          res_o     = make_chan(cur_q, first_q, b, dt);
        end
        PH_STOPPED, PH_HEADER, PH_META_TYPE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STOPPED;
      hcnt_q  <= '0;
      acc_q   <= '0;
      delta_q <= '0;
      last_q  <= STATUS_NONE;
      cur_q   <= STATUS_NONE;
      first_q <= '0;
      mtype_q <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      acc_q   <= acc_d;
      delta_q <= delta_d;
      last_q  <= last_d;
      cur_q   <= cur_d;
      first_q <= first_d;
      mtype_q <= mtype_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mtep_out_reg.sv @@
//------------------------------------------------------------------------------
// Result register
// Holds one event word until the downstream side takes it.
//------------------------------------------------------------------------------
`default_nettype none

module mtep_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire mtep_pkg::res_t res_i,
  output logic                free_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output mtep_pkg::res_t      res_o
);
  import mtep_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ rtl/core/midi_track_event_parser.sv @@
//------------------------------------------------------------------------------
// MIDI track event parser
// An event word enters the result register as its last byte is stepped.
// Throughput: 1 byte per cycle; the phase state machine updates once per byte.
// A held event word stalls the parser step, and with it the input register.
// Reset (rst_ni low, asynchronous): parser stopped until a track start, both
// registers empty, running status cleared.
//------------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser #(
  parameter int unsigned QuantityBits = mtep_pkg::QUANTITY_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mtep_in_if.sink     in_i,
  mtep_out_if.source  out_o
);
  import mtep_pkg::*;

  logic     word_vld;
  in_word_t word;
  logic     slot_free;
  logic     step;
  logic     res_vld;
  res_t     res;

  assign step = word_vld && slot_free;

  mtep_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .word_i  (in_i.data),
    .take_i  (step),
    .valid_o (word_vld),
    .word_o  (word)
  );

  mtep_step #(
    .QuantityBits (QuantityBits)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .word_i    (word),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  mtep_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_vld),
    .res_i   (res),
    .free_o  (slot_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_o.data)
  );

endmodule

`default_nettype wire

@@ rtl/core/mtep_checker.sv @@
//------------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level properties of the event channel, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module mtep_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire mtep_pkg::res_t out_data_i
);
  import mtep_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("event word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("event word changed while stalled");

  a_end_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.end_of_track |->
      out_data_i.event_kind == KIND_META && out_data_i.meta_type == META_END_TRACK &&
      out_data_i.payload_length == '0 && out_data_i.payload_byte == 8'h00 &&
      out_data_i.last_of_payload)
    else $error("end of track on a word that is not an empty end-of-track meta");

  a_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.event_kind != KIND_META &&
      out_data_i.event_kind != KIND_SYSEX |->
      out_data_i.payload_length == '0 && !out_data_i.last_of_payload &&
      out_data_i.meta_type == 8'h00 && !out_data_i.end_of_track)
    else $error("payload fields set on a non-payload word");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
